// ===== design/bao_pkg.sv =====
// ============================================================================
// bao_pkg: shared types and constants of the bias and activation output stage
// Lane count, value type, configuration record, register indexes, operation
// codes and the beat record that passes from the front end to the back end.
// ============================================================================
package bao_pkg;

    // Lanes carried by one beat and the width of one fixed-point value.
    localparam int LANES = 8;
    localparam int VAL_W = 16;

    // Depth of the queue between the front end and the back end.
    localparam int Q_DEPTH = 4;

    // Division of the hard-swish product by three: multiply by the rounded-up
    // reciprocal and shift. The offset keeps the dividend non-negative.
    localparam logic [18:0] HS_RECIP = 19'd349526;
    localparam int          HS_SHIFT = 20;
    localparam int          HS_OFFSET = 98304;

    typedef logic signed [VAL_W-1:0] t_val;

    // Operation codes of an input beat.
    localparam logic OP_BIAS = 1'b0;
    localparam logic OP_DATA = 1'b1;

    // Activation modes; the unused code behaves as no activation.
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_RELU   = 2'd1;
    localparam logic [1:0] MODE_HSWISH = 2'd2;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_ACTIVE_CHANNELS,
        REG_TILE_ROWS,
        REG_TILE_COLS,
        REG_ACTIVATION_MODE
    } t_reg_idx;

    typedef struct packed {
        logic [5:0] active_channels;
        logic [4:0] tile_rows;
        logic [4:0] tile_cols;
        logic [1:0] activation_mode;
    } t_cfg;

    // One classified data beat: biased lane values, lane enables, tile end.
    typedef struct packed {
        logic [LANES-1:0][VAL_W-1:0] x;
        logic [LANES-1:0]            lane_on;
        logic                        last;
    } t_beat;

endpackage

// ===== design/bias_activation_output_stage.sv =====
// ============================================================================
// bias_activation_output_stage: bias, activation and output of a conv tile
// Bias beats load eight biases of one channel group; data beats are biased,
// activated (none, ReLU, hard-swish) and returned with a tile-end flag.
// ============================================================================
//
//  Channel   Direction  Handshake                 Payload
//  input     in         i_valid / o_stall         i_op, i_value_lane0..7
//  output    out        o_valid / i_stall         o_out_lane0..7, o_last_beat
//  config    in         psel, penable, pready     paddr, pwdata, prdata
//
// One beat is taken every cycle while o_stall is low. A data beat's result is
// offered after it has passed the bias store read register (the bias adder
// follows it), the queue entry and the four activation stages (clamp,
// product, divide, select); the first of these is loaded at the accepting
// edge itself.
// Reset is synchronous and clears pointers, valid flags and registers; the
// bias store is not cleared and needs bias beats before data beats.
// A four-entry queue parts the front end from the activation pipeline, so
// an output stall holds the input only once the queue has filled.
//
module bias_activation_output_stage
    import bao_pkg::*;
#(
    parameter int CHANNELS  = 32,
    parameter int GROUPS    = 4,
    parameter int MAX_ROWS  = 16,
    parameter int MAX_COLS  = 16,
    parameter int FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input beats
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  t_val        i_value_lane0,
    input  t_val        i_value_lane1,
    input  t_val        i_value_lane2,
    input  t_val        i_value_lane3,
    input  t_val        i_value_lane4,
    input  t_val        i_value_lane5,
    input  t_val        i_value_lane6,
    input  t_val        i_value_lane7,
    // Result beats
    output logic        o_valid,
    input  logic        i_stall,
    output t_val        o_out_lane0,
    output t_val        o_out_lane1,
    output t_val        o_out_lane2,
    output t_val        o_out_lane3,
    output t_val        o_out_lane4,
    output t_val        o_out_lane5,
    output t_val        o_out_lane6,
    output t_val        o_out_lane7,
    output logic        o_last_beat
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_write;

    t_val  value [LANES];
    t_val  out_val [LANES];
    logic  q_push, q_full, q_pop, q_valid;
    t_beat q_in, q_out;

    // Register file: always ready, written on the access cycle.
    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_channels <= 6'd32;
            r_cfg.tile_rows       <= 5'd16;
            r_cfg.tile_cols       <= 5'd16;
            r_cfg.activation_mode <= MODE_NONE;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_ACTIVE_CHANNELS: r_cfg.active_channels <= pwdata[5:0];
                REG_TILE_ROWS:       r_cfg.tile_rows       <= pwdata[4:0];
                REG_TILE_COLS:       r_cfg.tile_cols       <= pwdata[4:0];
                REG_ACTIVATION_MODE: r_cfg.activation_mode <= pwdata[1:0];
                default:             r_cfg <= r_cfg;
            endcase
        end
    end

    // Read-back of the register file.
    always_comb begin
        case (reg_idx)
            REG_ACTIVE_CHANNELS: prdata = {26'd0, r_cfg.active_channels};
            REG_TILE_ROWS:       prdata = {27'd0, r_cfg.tile_rows};
            REG_TILE_COLS:       prdata = {27'd0, r_cfg.tile_cols};
            REG_ACTIVATION_MODE: prdata = {30'd0, r_cfg.activation_mode};
            default:             prdata = '0;
        endcase
    end

    // Lane ports gathered into arrays.
    assign value[0] = i_value_lane0;
    assign value[1] = i_value_lane1;
    assign value[2] = i_value_lane2;
    assign value[3] = i_value_lane3;
    assign value[4] = i_value_lane4;
    assign value[5] = i_value_lane5;
    assign value[6] = i_value_lane6;
    assign value[7] = i_value_lane7;

    assign o_out_lane0 = out_val[0];
    assign o_out_lane1 = out_val[1];
    assign o_out_lane2 = out_val[2];
    assign o_out_lane3 = out_val[3];
    assign o_out_lane4 = out_val[4];
    assign o_out_lane5 = out_val[5];
    assign o_out_lane6 = out_val[6];
    assign o_out_lane7 = out_val[7];

    // Front end: bias store, tile walk and bias addition.
    bao_front #(
        .CHANNELS (CHANNELS),
        .GROUPS   (GROUPS),
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_op    (i_op),
        .i_value (value),
        .o_push  (q_push),
        .o_beat  (q_in),
        .i_full  (q_full)
    );

    // Queue between the two halves.
    bao_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_beat  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_beat  (q_out)
    );

    // Back end: activation pipeline and output register.
    bao_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .o_pop   (q_pop),
        .i_beat  (q_out),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (out_val),
        .o_last  (o_last_beat)
    );

endmodule

// ===== design/bao_front.sv =====
// ============================================================================
// bao_front: beat acceptance, bias store and tile walk
// Writes bias beats into the bias store, walks group, row and column for data
// beats, reads the group's biases and adds them, then hands beats to a queue.
// ============================================================================
module bao_front
    import bao_pkg::*;
#(
    parameter int CHANNELS = 32,
    parameter int GROUPS   = 4,
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    output logic  o_stall,
    input  logic  i_op,
    input  t_val  i_value [LANES],
    output logic  o_push,
    output t_beat o_beat,
    input  logic  i_full
);

    localparam int GPW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int RPW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CPW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_BITS = LANES * VAL_W;

    logic [GPW-1:0] r_bias_grp, r_out_grp;
    logic [RPW-1:0] r_out_row;
    logic [CPW-1:0] r_out_col;

    logic [ROW_BITS-1:0] r_bias_mem [GROUPS];
    logic [ROW_BITS-1:0] r_rd_row;
    logic [ROW_BITS-1:0] wr_row;

    logic             r_f1_valid;
    t_val             r_f1_sum [LANES];
    logic [LANES-1:0] r_f1_on, r_f1_bias_ok;
    logic             r_f1_last;

    logic             accept, accept_data, accept_bias;
    logic [7:0]       rows_eff, cols_eff;
    logic             col_end, row_end, grp_end;
    logic [LANES-1:0] lane_on, bias_ok;

    // A beat waits in the second stage only while the queue is full.
    assign o_stall     = r_f1_valid && i_full;
    assign accept      = i_valid && !o_stall;
    assign accept_data = accept && (i_op == OP_DATA);
    assign accept_bias = accept && (i_op == OP_BIAS);

    // Effective tile geometry: zero counts as one, excess is capped.
    always_comb begin
        if (i_cfg.tile_rows == 5'd0) begin
            rows_eff = 8'd1;
        end else if ({3'b0, i_cfg.tile_rows} > 8'(MAX_ROWS)) begin
            rows_eff = 8'(MAX_ROWS);
        end else begin
            rows_eff = {3'b0, i_cfg.tile_rows};
        end
        if (i_cfg.tile_cols == 5'd0) begin
            cols_eff = 8'd1;
        end else if ({3'b0, i_cfg.tile_cols} > 8'(MAX_COLS)) begin
            cols_eff = 8'(MAX_COLS);
        end else begin
            cols_eff = {3'b0, i_cfg.tile_cols};
        end
    end

    assign col_end = (8'(r_out_col) + 8'd1) >= cols_eff;
    assign row_end = (8'(r_out_row) + 8'd1) >= rows_eff;
    assign grp_end = (8'(r_out_grp) + 8'd1) >= 8'(GROUPS);

    // Per-lane channel tests for the current output group.
    always_comb begin
        logic [8:0] ch;
        for (int l = 0; l < LANES; l++) begin
            ch         = 9'(r_out_grp) * 9'(LANES) + 9'(l);
            lane_on[l] = ch < {3'b0, i_cfg.active_channels};
            bias_ok[l] = ch < 9'(CHANNELS);
        end
    end

    // Packing of a bias beat into one store row.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            wr_row[l*VAL_W +: VAL_W] = i_value[l];
        end
    end

    // Bias store: one row per channel group, registered read.
    always_ff @(posedge i_clk) begin
        if (accept_bias) begin
            r_bias_mem[r_bias_grp] <= wr_row;
        end
        if (accept_data) begin
            r_rd_row <= r_bias_mem[r_out_grp];
        end
    end

    // Group, row and column pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_grp <= '0;
            r_out_grp  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
        end else begin
            if (accept_bias) begin
                r_bias_grp <= ((8'(r_bias_grp) + 8'd1) >= 8'(GROUPS)) ? '0
                                                                       : r_bias_grp + 1'b1;
            end
            if (accept_data) begin
                if (col_end) begin
                    r_out_col <= '0;
                    if (row_end) begin
                        r_out_row <= '0;
                        r_out_grp <= grp_end ? '0 : r_out_grp + 1'b1;
                    end else begin
                        r_out_row <= r_out_row + 1'b1;
                    end
                end else begin
                    r_out_col <= r_out_col + 1'b1;
                end
            end
        end
    end

    // Second stage: holds a data beat until the queue takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else if (!o_stall) begin
            r_f1_valid <= accept_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_data) begin
            r_f1_sum     <= i_value;
            r_f1_on      <= lane_on;
            r_f1_bias_ok <= bias_ok;
            r_f1_last    <= col_end && row_end && grp_end;
        end
    end

    // Bias addition, wrapping at sixteen bits.
    always_comb begin
        logic [VAL_W-1:0] b;
        for (int l = 0; l < LANES; l++) begin
            b = r_f1_bias_ok[l] ? r_rd_row[l*VAL_W +: VAL_W] : '0;
            o_beat.x[l] = r_f1_sum[l] + b;
        end
        o_beat.lane_on = r_f1_on;
        o_beat.last    = r_f1_last;
    end

    assign o_push = r_f1_valid && !i_full;

`ifndef NO_ASSERTIONS
    // A bias beat taken without a stall leaves nothing for the queue.
    a_bias_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept_bias |=> !r_f1_valid)
        else $error("bias beat produced a queued result");

    // A data beat taken without a stall always reaches the second stage.
    a_data_staged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept_data |=> r_f1_valid)
        else $error("data beat lost before the queue");
`endif

endmodule

// ===== design/bao_queue.sv =====
// ============================================================================
// bao_queue: short beat queue between front end and back end
// A small first-in first-out store that lets either side stall on its own.
// ============================================================================
module bao_queue
    import bao_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_beat i_beat,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_beat o_beat
);

    localparam int QPW = $clog2(Q_DEPTH);

    t_beat          r_mem [Q_DEPTH];
    logic [QPW-1:0] r_wr, r_rd;
    logic [QPW:0]   r_count;

    assign o_full  = r_count == (QPW+1)'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_beat  = r_mem[r_rd];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_beat;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    // The back end never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
`endif

endmodule

// ===== design/bao_back.sv =====
// ============================================================================
// bao_back: activation pipeline and output register
// Applies none, ReLU or hard-swish to each lane over four stages: clamp,
// product, division by six, then selection into the output register.
// ============================================================================
module bao_back
    import bao_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    output logic  o_pop,
    input  t_beat i_beat,
    output logic  o_valid,
    input  logic  i_stall,
    output t_val  o_out [LANES],
    output logic  o_last
);

    localparam logic [VAL_W-1:0] THREE = VAL_W'(3 << FRAC_BITS);
    localparam logic [VAL_W:0]   SIX   = (VAL_W+1)'(6 << FRAC_BITS);

    // Stage registers: valid, lane values, enables and tile end travel along.
    logic             r_s1_valid, r_s2_valid, r_s3_valid;
    t_val             r_s1_x [LANES];
    t_val             r_s2_x [LANES];
    t_val             r_s3_x [LANES];
    logic [LANES-1:0] r_s1_on, r_s2_on, r_s3_on;
    logic             r_s1_last, r_s2_last, r_s3_last;

    logic signed [VAL_W+1:0] r_s1_d [LANES];
    logic signed [33:0]      r_s2_p [LANES];
    logic [36:0]             r_s3_m [LANES];

    logic out_free, s3_free, s2_free, s1_free;

    // Each stage moves on when the one after it is empty or moving.
    assign out_free = !o_valid || !i_stall;
    assign s3_free  = !r_s3_valid || out_free;
    assign s2_free  = !r_s2_valid || s3_free;
    assign s1_free  = !r_s1_valid || s2_free;
    assign o_pop    = i_valid && s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_valid;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_free) begin
                r_s3_valid <= r_s2_valid;
            end
            if (out_free) begin
                o_valid <= r_s3_valid;
            end
        end
    end

    // Stage one: hard-swish gate, clamp(x + 3, 0, 6).
    always_ff @(posedge i_clk) begin
        logic [VAL_W-1:0] t;
        if (s1_free) begin
            for (int l = 0; l < LANES; l++) begin
                t         = i_beat.x[l] + THREE;
                r_s1_x[l] <= t_val'(i_beat.x[l]);
                if (t[VAL_W-1]) begin
                    r_s1_d[l] <= '0;
                end else if ({1'b0, t} > SIX) begin
                    r_s1_d[l] <= signed'({1'b0, SIX});
                end else begin
                    r_s1_d[l] <= signed'({2'b00, t});
                end
            end
            r_s1_on   <= i_beat.lane_on;
            r_s1_last <= i_beat.last;
        end
    end

    // Stage two: product of gate and value.
    always_ff @(posedge i_clk) begin
        if (s2_free) begin
            for (int l = 0; l < LANES; l++) begin
                r_s2_p[l] <= r_s1_d[l] * r_s1_x[l];
            end
            r_s2_x    <= r_s1_x;
            r_s2_on   <= r_s1_on;
            r_s2_last <= r_s1_last;
        end
    end

    // Stage three: floor division by six steps of one, as a shift by
    // FRAC_BITS+1 and a reciprocal multiply for the factor three.
    always_ff @(posedge i_clk) begin
        logic signed [17:0] q;
        logic signed [18:0] n;
        if (s3_free) begin
            for (int l = 0; l < LANES; l++) begin
                q         = 18'(r_s2_p[l] >>> (FRAC_BITS + 1));
                n         = 19'(q) + 19'(HS_OFFSET);
                r_s3_m[l] <= 37'(n[17:0]) * 37'(HS_RECIP);
            end
            r_s3_x    <= r_s2_x;
            r_s3_on   <= r_s2_on;
            r_s3_last <= r_s2_last;
        end
    end

    // Output register: mode selection and inactive lanes forced to zero.
    always_ff @(posedge i_clk) begin
        t_val hs;
        if (out_free) begin
            for (int l = 0; l < LANES; l++) begin
                hs = t_val'(r_s3_m[l][HS_SHIFT +: VAL_W] ^ 16'h8000);
                if (!r_s3_on[l]) begin
                    o_out[l] <= '0;
                end else begin
                    case (i_cfg.activation_mode)
                        MODE_RELU:   o_out[l] <= r_s3_x[l][VAL_W-1] ? '0 : r_s3_x[l];
                        MODE_HSWISH: o_out[l] <= hs;
                        default:     o_out[l] <= r_s3_x[l];
                    endcase
                end
            end
            o_last <= r_s3_last;
        end
    end

`ifndef NO_ASSERTIONS
    // A waiting result is never overwritten while the output is stalled.
    a_hold_under_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_last)))
        else $error("stalled result changed");
`endif

endmodule
